// File: hdl/first_fit_slot_allocator_top_defines.svh
// assertion macros for the slot allocator
`ifndef FIRST_FIT_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_SLOT_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define FFSA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ffsa check failed");

`define FFSA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ffsa check failed");

`else

`define FFSA_ASSERT_IMP(lbl, ante, cons)
`define FFSA_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// File: hdl/ffsa_pkg.sv
package ffsa_pkg;

	localparam int KEY_W = 31;
	typedef logic [KEY_W-1:0] key_t;

	typedef logic [1:0] op_t;
	localparam op_t OP_CLEAR = 2'd0;
	localparam op_t OP_LOAD  = 2'd1;
	localparam op_t OP_PLACE = 2'd2;

	localparam key_t KEY_EMPTY = '0;

endpackage

// File: hdl/first_fit_slot_allocator_top.sv
// First-fit slot allocator over a max tree held in one node memory
// (2*L entries, L = SLOTS rounded up to a power of two, D = log2(L) levels).
// One request beat is taken at a time; req_stall is high while a beat is in
// work. A place that finds a slot makes one memory read per level going
// down, then one read and one write per level going back up; a load writes
// its leaf and walks back up, and a place that misses stops at the root.
// A clear, and the start after reset, sweeps the node memory one entry a
// cycle. A place gives one response beat, held in an output register;
// clear and load give none.
`include "first_fit_slot_allocator_top_defines.svh"

module first_fit_slot_allocator_top #(
	parameter int SLOTS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  ffsa_pkg::op_t       operation,
	input  logic [9:0]          slot_index,
	input  logic [29:0]         amount,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic                found,
	output logic [9:0]          taken_slot,
	output logic [31:0]         unplaced_count
);
	import ffsa_pkg::*;

	localparam int LEVELS = $clog2(SLOTS);
	localparam int NW     = LEVELS + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CLR  = 3'd1;
	localparam logic [2:0] ST_ROOT = 3'd2;
	localparam logic [2:0] ST_DOWN = 3'd3;
	localparam logic [2:0] ST_LEAF = 3'd4;
	localparam logic [2:0] ST_UP   = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	logic [2:0]    state_q;
	logic [NW-1:0] node_q;
	logic [NW-1:0] clr_q;
	key_t          val_q;
	key_t          key_q;
	logic          place_q;
	logic          hit_q;
	logic [9:0]    slot_q;
	logic [31:0]   miss_q;

	logic          rsp_valid_q;
	logic          found_q;
	logic [9:0]    taken_q;
	logic [31:0]   count_q;

	logic          we;
	logic [NW-1:0] waddr;
	key_t          wdata;
	logic [NW-1:0] raddr;
	key_t          rdata;

	logic                 accept;
	key_t                 key_in;
	logic [LEVELS+9:0]    slot_wide;
	logic [NW-1:0]        leaf_in;
	logic                 slot_ok;
	logic [NW-1:0]        next_node;
	logic [NW-1:0]        parent;
	key_t                 up_val;
	logic [LEVELS+9:0]    taken_wide;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign key_in    = {1'b0, amount} + key_t'(1);
	assign slot_wide = (LEVELS+10)'(slot_index);
	assign leaf_in   = {1'b1, slot_wide[LEVELS-1:0]};
	assign slot_ok   = (32'(slot_index) < 32'(SLOTS));
	assign next_node = (rdata >= key_q) ? {node_q[NW-2:0], 1'b0} : {node_q[NW-2:0], 1'b1};
	assign parent    = node_q >> 1;
	assign up_val    = (val_q > rdata) ? val_q : rdata;
	assign taken_wide = (LEVELS+10)'(next_node[LEVELS-1:0]);

	// memory port control
	always_comb begin
		we    = 1'b0;
		waddr = node_q;
		wdata = val_q;
		raddr = node_q ^ NW'(1);
		case (state_q)
			ST_IDLE: begin
				raddr = NW'(1);
			end
			ST_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = KEY_EMPTY;
			end
			ST_ROOT: begin
				raddr = NW'(2);
			end
			ST_DOWN: begin
				raddr = {next_node[NW-2:0], 1'b0};
			end
			ST_LEAF: begin
				we = 1'b1;
			end
			ST_UP: begin
				we    = 1'b1;
				waddr = parent;
				wdata = up_val;
				raddr = parent ^ NW'(1);
			end
			default: begin
			end
		endcase
	end

	ffsa_node_ram #(
		.ADDR_W(NW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			miss_q  <= '0;
			node_q  <= '0;
			place_q <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (operation)
							OP_CLEAR: begin
								miss_q  <= '0;
								clr_q   <= '0;
								state_q <= ST_CLR;
							end
							OP_LOAD: begin
								if (slot_ok) begin
									node_q  <= leaf_in;
									place_q <= 1'b0;
									state_q <= ST_LEAF;
								end
							end
							OP_PLACE: begin
								place_q <= 1'b1;
								state_q <= ST_ROOT;
							end
							default: begin
							end
						endcase
					end
				end
				ST_CLR: begin
					clr_q <= clr_q + NW'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ROOT: begin
					if (rdata >= key_q) begin
						node_q  <= NW'(1);
						state_q <= ST_DOWN;
					end else begin
						hit_q <= 1'b0;
						if (miss_q != '1) begin
							miss_q <= miss_q + 32'd1;
						end
						state_q <= ST_FIN;
					end
				end
				ST_DOWN: begin
					node_q <= next_node;
					if (next_node[LEVELS]) begin
						hit_q   <= 1'b1;
						state_q <= ST_LEAF;
					end
				end
				ST_LEAF: begin
					state_q <= ST_UP;
				end
				ST_UP: begin
					node_q <= parent;
					if (parent == NW'(1)) begin
						state_q <= place_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_FIN: begin
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= key_in;
			val_q <= key_in;
		end
		case (state_q)
			ST_ROOT: begin
				slot_q <= '0;
			end
			ST_DOWN: begin
				if (next_node[LEVELS]) begin
					val_q  <= KEY_EMPTY;
					slot_q <= taken_wide[9:0];
				end
			end
			ST_UP: begin
				val_q <= up_val;
			end
			default: begin
			end
		endcase
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && (!rsp_valid_q || !rsp_stall)) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && (!rsp_valid_q || !rsp_stall)) begin
			found_q <= hit_q;
			taken_q <= slot_q;
			count_q <= miss_q;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign found          = found_q;
	assign taken_slot     = taken_q;
	assign unplaced_count = count_q;

	`FFSA_ASSERT_IMP(a_new_beat_from_fin, $rose(rsp_valid), $past(state_q) == ST_FIN)
	`FFSA_ASSERT_IMP(a_down_internal, state_q == ST_DOWN, !node_q[LEVELS])
	`FFSA_ASSERT_IMP(a_up_below_root, state_q == ST_UP, node_q > NW'(1))
	`FFSA_ASSERT_NXT(a_miss_step, state_q != ST_IDLE && state_q != ST_ROOT, miss_q == $past(miss_q))

endmodule

// File: hdl/ffsa_node_ram.sv
module ffsa_node_ram #(
	parameter int ADDR_W = 11
) (
	input  logic                clk,
	input  logic                we,
	input  logic [ADDR_W-1:0]   waddr,
	input  ffsa_pkg::key_t      wdata,
	input  logic [ADDR_W-1:0]   raddr,
	output ffsa_pkg::key_t      rdata
);
	import ffsa_pkg::*;

	key_t mem [2**ADDR_W];
	key_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
